// ----- rtl/ghi_pkg.sv -----
// ----------------------------------------------------------------------------
// ghi_pkg
// Shared types and constants of the interleaved score codec: coordinate
// widths, the fixed-point bounds of both axes and the pipeline control word.
// ----------------------------------------------------------------------------
package ghi_pkg;

	// Number of bisection steps per axis; the score holds two bits per step.
	localparam int STEP_BITS_DEF = 26;

	// Coordinate widths, signed Q32 degrees.
	localparam int LON_W = 41;
	localparam int LAT_W = 40;

	// Axis bounds in Q32: 180 degrees exactly, 85.05112878 degrees rounded.
	localparam logic signed [LON_W-1:0] LON_BOUND = 41'sd773094113280;
	localparam logic signed [LAT_W-1:0] LAT_BOUND = 40'sd365291816598;

	// Operation codes of the action field.
	localparam logic ACT_ENCODE = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	// Control word that travels alongside the data through every stage.
	typedef struct packed {
		logic valid;
		logic decode;
		logic err;
	} ghi_ctl_t;

endpackage

// ----- rtl/geohash_interleave_codec.sv -----
// ----------------------------------------------------------------------------
// geohash_interleave_codec
// Interleaved score codec: encodes a longitude/latitude pair into a score of
// two bits per bisection step, or decodes a score into its cell centre.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | into      | in_valid / in_stall  | action, longitude_in, latitude_in,
//          |           |                      | score_in
//  out     | out of    | out_valid / out_stall| score_out, longitude_out,
//          |           |                      | latitude_out, range_error
//
// Every item passes an entry register, one register stage per bisection step
// and an output register. A new item is taken in every cycle while in_stall
// is low. The pipeline advances as a whole on one enable that is low only
// while a result sits in the output register and the receiver stalls; then
// in_stall is raised and every stage holds. Reset clears the valid bits of
// all stages and of the output register; the data registers are not reset.
//
// Encode checks both coordinates against their closed bounds at entry; an out
// of range pair yields range_error with a zero score. Decode ignores the
// coordinate inputs and reports the midpoint of the final interval on each
// axis. Midpoints are truncated toward zero throughout.
// ----------------------------------------------------------------------------
module geohash_interleave_codec #(
	parameter int STEP_BITS = ghi_pkg::STEP_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic signed [ghi_pkg::LON_W-1:0] longitude_in,
	input  logic signed [ghi_pkg::LON_W-1:0] latitude_in,
	input  logic        [2*STEP_BITS-1:0]   score_in,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic        [2*STEP_BITS-1:0]   score_out,
	output logic signed [ghi_pkg::LON_W-1:0] longitude_out,
	output logic signed [ghi_pkg::LAT_W-1:0] latitude_out,
	output logic                            range_error
);
	import ghi_pkg::*;

	localparam int SW = 2 * STEP_BITS;

	// Pipeline enable: everything moves unless a finished result is held up.
	logic en;

	// Entry register.
	ghi_ctl_t                ctl_s1;
	logic signed [LON_W-1:0] lon_s1;
	logic signed [LAT_W-1:0] lat_s1;
	logic        [SW-1:0]    score_s1;
	logic                    out_of_range;

	// Signals between bisection stages; index 0 is the entry side.
	ghi_ctl_t                st_ctl    [0:STEP_BITS];
	logic signed [LON_W-1:0] st_lon    [0:STEP_BITS];
	logic signed [LAT_W-1:0] st_lat    [0:STEP_BITS];
	logic signed [LON_W-1:0] st_lon_lo [0:STEP_BITS];
	logic signed [LON_W-1:0] st_lon_hi [0:STEP_BITS];
	logic signed [LAT_W-1:0] st_lat_lo [0:STEP_BITS];
	logic signed [LAT_W-1:0] st_lat_hi [0:STEP_BITS];
	logic        [SW-1:0]    st_score  [0:STEP_BITS];

	// Final cell centres and output register.
	logic signed [LON_W-1:0] lon_centre;
	logic signed [LAT_W-1:0] lat_centre;
	logic                    out_valid_q;
	logic        [SW-1:0]    score_q;
	logic signed [LON_W-1:0] lon_q;
	logic signed [LAT_W-1:0] lat_q;
	logic                    err_q;

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// Both bounds are inclusive.
	assign out_of_range = (longitude_in < -LON_BOUND) || (longitude_in > LON_BOUND) ||
		(latitude_in < -LAT_BOUND) || (latitude_in > LAT_BOUND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid  <= in_valid;
			ctl_s1.decode <= action;
			ctl_s1.err    <= (action == ACT_ENCODE) && out_of_range;
		end
	end

	// When the latitude is in range it fits the narrower width exactly; when it
	// is not, the error flag discards whatever the steps make of it.
	always_ff @(posedge clk) begin
		if (en) begin
			lon_s1   <= longitude_in;
			lat_s1   <= latitude_in[LAT_W-1:0];
			score_s1 <= score_in;
		end
	end

	assign st_ctl[0]    = ctl_s1;
	assign st_lon[0]    = lon_s1;
	assign st_lat[0]    = lat_s1;
	assign st_lon_lo[0] = -LON_BOUND;
	assign st_lon_hi[0] = LON_BOUND;
	assign st_lat_lo[0] = -LAT_BOUND;
	assign st_lat_hi[0] = LAT_BOUND;
	assign st_score[0]  = score_s1;

	for (genvar g = 0; g < STEP_BITS; g++) begin : g_step
		ghi_stage #(.STEP_BITS(STEP_BITS)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.ctl       (st_ctl[g]),
			.lon       (st_lon[g]),
			.lat       (st_lat[g]),
			.lon_lo    (st_lon_lo[g]),
			.lon_hi    (st_lon_hi[g]),
			.lat_lo    (st_lat_lo[g]),
			.lat_hi    (st_lat_hi[g]),
			.score     (st_score[g]),
			.ctl_sn    (st_ctl[g+1]),
			.lon_sn    (st_lon[g+1]),
			.lat_sn    (st_lat[g+1]),
			.lon_lo_sn (st_lon_lo[g+1]),
			.lon_hi_sn (st_lon_hi[g+1]),
			.lat_lo_sn (st_lat_lo[g+1]),
			.lat_hi_sn (st_lat_hi[g+1]),
			.score_sn  (st_score[g+1])
		);
	end

	// The centre of the last interval is the decoded coordinate.
	ghi_midpoint #(.W(LON_W)) u_lon_centre (
		.lo  (st_lon_lo[STEP_BITS]),
		.hi  (st_lon_hi[STEP_BITS]),
		.mid (lon_centre)
	);
	ghi_midpoint #(.W(LAT_W)) u_lat_centre (
		.lo  (st_lat_lo[STEP_BITS]),
		.hi  (st_lat_hi[STEP_BITS]),
		.mid (lat_centre)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= st_ctl[STEP_BITS].valid;
		end
	end

	// Encode results carry no coordinates and decode results carry no score.
	always_ff @(posedge clk) begin
		if (en) begin
			err_q <= st_ctl[STEP_BITS].err;
			if (st_ctl[STEP_BITS].decode == ACT_DECODE) begin
				score_q <= '0;
				lon_q   <= lon_centre;
				lat_q   <= lat_centre;
			end else begin
				score_q <= st_ctl[STEP_BITS].err ? '0 : st_score[STEP_BITS];
				lon_q   <= '0;
				lat_q   <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign score_out     = score_q;
	assign longitude_out = lon_q;
	assign latitude_out  = lat_q;
	assign range_error   = err_q;

`ifndef SYNTHESIS
	// A flagged encode never delivers a score.
	a_err_no_score: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> score_out == '0)
		else $error("range error delivered with a non-zero score");

	// A non-zero score comes from an encode, which reports no coordinates.
	a_score_no_coords: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && score_out != '0 |-> longitude_out == '0 && latitude_out == '0)
		else $error("encoded score delivered together with coordinates");

	// Decoded latitudes stay inside the latitude bounds.
	a_lat_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> latitude_out >= -LAT_BOUND && latitude_out <= LAT_BOUND)
		else $error("decoded latitude outside its bounds");

	// The input is held exactly when a result waits in the output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not match a waiting result");
`endif

endmodule

// ----- rtl/ghi_midpoint.sv -----
// ----------------------------------------------------------------------------
// ghi_midpoint
// Midpoint of a fixed-point interval, (lo + hi) / 2 truncated toward zero.
// ----------------------------------------------------------------------------
module ghi_midpoint #(
	parameter int W = 41
) (
	input  logic signed [W-1:0] lo,
	input  logic signed [W-1:0] hi,
	output logic signed [W-1:0] mid
);
	logic signed [W:0] sum;
	logic        [W:0] adj;

	// A negative sum is nudged up by one so that the halving rounds toward zero.
	assign sum = (W+1)'(lo) + (W+1)'(hi);
	assign adj = sum + (W+1)'(sum[W]);
	assign mid = adj[W:1];

endmodule

// ----- rtl/ghi_stage.sv -----
// ----------------------------------------------------------------------------
// ghi_stage
// One registered bisection step for both axes. Encode compares each
// coordinate with the interval midpoint; decode takes the two leading score
// bits instead. The score shifts left by two and takes in the step's bits.
// ----------------------------------------------------------------------------
module ghi_stage #(
	parameter int STEP_BITS = ghi_pkg::STEP_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  ghi_pkg::ghi_ctl_t               ctl,
	input  logic signed [ghi_pkg::LON_W-1:0] lon,
	input  logic signed [ghi_pkg::LAT_W-1:0] lat,
	input  logic signed [ghi_pkg::LON_W-1:0] lon_lo,
	input  logic signed [ghi_pkg::LON_W-1:0] lon_hi,
	input  logic signed [ghi_pkg::LAT_W-1:0] lat_lo,
	input  logic signed [ghi_pkg::LAT_W-1:0] lat_hi,
	input  logic        [2*STEP_BITS-1:0]   score,
	output ghi_pkg::ghi_ctl_t               ctl_sn,
	output logic signed [ghi_pkg::LON_W-1:0] lon_sn,
	output logic signed [ghi_pkg::LAT_W-1:0] lat_sn,
	output logic signed [ghi_pkg::LON_W-1:0] lon_lo_sn,
	output logic signed [ghi_pkg::LON_W-1:0] lon_hi_sn,
	output logic signed [ghi_pkg::LAT_W-1:0] lat_lo_sn,
	output logic signed [ghi_pkg::LAT_W-1:0] lat_hi_sn,
	output logic        [2*STEP_BITS-1:0]   score_sn
);
	import ghi_pkg::*;

	localparam int SW = 2 * STEP_BITS;

	logic signed [LON_W-1:0] lon_mid;
	logic signed [LAT_W-1:0] lat_mid;
	logic                    lon_bit;
	logic                    lat_bit;
	logic        [SW+1:0]    score_ext;

	ghi_midpoint #(.W(LON_W)) u_lon_mid (.lo(lon_lo), .hi(lon_hi), .mid(lon_mid));
	ghi_midpoint #(.W(LAT_W)) u_lat_mid (.lo(lat_lo), .hi(lat_hi), .mid(lat_mid));

	always_comb begin
		if (ctl.decode == ACT_DECODE) begin
			lon_bit = score[SW-1];
			lat_bit = score[SW-2];
		end else begin
			lon_bit = (lon >= lon_mid);
			lat_bit = (lat >= lat_mid);
		end
	end

	assign score_ext = {score, lon_bit, lat_bit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sn <= '0;
		end else if (en) begin
			ctl_sn <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lon_sn    <= lon;
			lat_sn    <= lat;
			lon_lo_sn <= lon_bit ? lon_mid : lon_lo;
			lon_hi_sn <= lon_bit ? lon_hi : lon_mid;
			lat_lo_sn <= lat_bit ? lat_mid : lat_lo;
			lat_hi_sn <= lat_bit ? lat_hi : lat_mid;
			score_sn  <= score_ext[SW-1:0];
		end
	end

endmodule
